>>> sv/sss_hypothesis_correlator_macros.svh
// Assertion macros shared by the SSS hypothesis correlator RTL.
`ifndef SSS_HYPOTHESIS_CORRELATOR_MACROS_SVH
`define SSS_HYPOTHESIS_CORRELATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("SSS correlator same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("SSS correlator next-cycle check failed");

`endif

>>> sv/shc_pkg.sv
// Shared types, constants and phase tables of the SSS hypothesis correlator.
package shc_pkg;

  localparam int SampleW = 16;
  localparam int MetricW = 24;
  localparam int ScoreW  = 28;
  localparam int CellW   = 9;
  localparam int PhaseW  = 3;
  localparam int GroupW  = 8;
  localparam int InDataW = 112;
  localparam int OutDataW = 64;

  localparam logic [PhaseW-1:0] ROW_LAST = 3'd6;
  localparam logic signed [ScoreW-1:0] START_SCORE = -28'sd99999999;
  localparam logic [CellW-1:0] GROUP_SIZE = 9'd168;

  // Control fields that travel beside the lane data.
  typedef struct packed {
    logic              valid;
    logic              start;
    logic              last;
    logic [PhaseW-1:0] phase;
    logic [GroupW-1:0] group;
  } shc_ctrl_t;

  // Cosine row of the Q15 phase table.
  function automatic logic signed [SampleW-1:0] rot_cos(input logic [PhaseW-1:0] ph);
    logic signed [SampleW-1:0] v;
    unique case (ph)
      3'd0:    v = 16'sd16383;
      3'd1:    v = 16'sd25101;
      3'd2:    v = 16'sd30791;
      3'd3:    v = 16'sd32767;
      3'd4:    v = 16'sd30791;
      3'd5:    v = 16'sd25101;
      default: v = 16'sd16383;
    endcase
    return v;
  endfunction

  // Sine row of the Q15 phase table.
  function automatic logic signed [SampleW-1:0] rot_sin(input logic [PhaseW-1:0] ph);
    logic signed [SampleW-1:0] v;
    unique case (ph)
      3'd0:    v = -16'sd28378;
      3'd1:    v = -16'sd21063;
      3'd2:    v = -16'sd11208;
      3'd3:    v = 16'sd0;
      3'd4:    v = 16'sd11207;
      3'd5:    v = 16'sd21062;
      default: v = 16'sd28377;
    endcase
    return v;
  endfunction

endpackage

>>> sv/shc_lane.sv
// One correlation lane: phase rotation of a sample and product with its reference value.
module shc_lane import shc_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [SampleW-1:0] samp_re,
  input  logic signed [SampleW-1:0] samp_im,
  input  logic signed [SampleW-1:0] ref_val,
  input  logic [PhaseW-1:0]         phase,
  output logic signed [SampleW-1:0] term
);

  logic signed [2*SampleW-1:0] prod_c_r, prod_s_r;
  logic [SampleW-1:0]          ref_r;
  logic [SampleW-1:0]          term_r;
  logic [SampleW-1:0]          rot_w;
  logic [2*SampleW-1:0]        mul_w;

  // First stage: the two rotation products.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_c_r <= rot_cos(phase) * samp_re;
      prod_s_r <= rot_sin(phase) * samp_im;
      ref_r    <= ref_val;
    end
  end

  // Floor shift by 15 of each product and their difference; only the low 16 bits
  // reach the truncated reference product.
  assign rot_w = prod_c_r[SampleW+14:15] - prod_s_r[SampleW+14:15];
  assign mul_w = (2*SampleW)'(rot_w) * (2*SampleW)'(ref_r);

  // Second stage: reference product cut to 16 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= mul_w[SampleW-1:0];
    end
  end

  assign term = $signed(term_r);

endmodule

>>> sv/shc_merge.sv
// Merge stage: running metric, best hypothesis tracking and result register.
`include "sss_hypothesis_correlator_macros.svh"
module shc_merge import shc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  shc_ctrl_t                 ctrl,
  input  logic signed [SampleW-1:0] term0,
  input  logic signed [SampleW-1:0] term1,
  input  logic                      id_group,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [MetricW-1:0]        metric,
  output logic [ScoreW-1:0]         score,
  output logic [CellW-1:0]          cell_id,
  output logic [PhaseW-1:0]         rotation,
  output logic                      improved,
  output logic                      hold
);

  logic [MetricW-1:0]       running_r, running_nxt;
  logic signed [ScoreW-1:0] best_r, best_nxt;
  logic [CellW-1:0]         best_id_r, best_id_nxt;
  logic [PhaseW-1:0]        best_ph_r, best_ph_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MetricW-1:0]       metric_r;
  logic [ScoreW-1:0]        score_r;
  logic [CellW-1:0]         cell_r;
  logic [PhaseW-1:0]        rotation_r;
  logic                     improved_r;

  logic [MetricW-1:0]       base_w, acc_w;
  logic signed [ScoreW-1:0] best_eff_w, metric_ext_w;
  logic                     better_w, take_w;
  logic [CellW-1:0]         cell_id_w;

  // A finishing element waits while the result register is still full.
  assign hold   = ctrl.valid && ctrl.last && out_valid_r && !out_ready;
  assign take_w = en && ctrl.valid;

  // Accumulate both lane terms; a search start clears the metric and resets the best score to its start value.
  always_comb begin
    base_w       = ctrl.start ? '0 : running_r;
    acc_w        = base_w + {{(MetricW-SampleW){term0[SampleW-1]}}, term0}
                          + {{(MetricW-SampleW){term1[SampleW-1]}}, term1};
    best_eff_w   = ctrl.start ? START_SCORE : best_r;
    metric_ext_w = $signed({{(ScoreW-MetricW){acc_w[MetricW-1]}}, acc_w});
    better_w     = metric_ext_w > best_eff_w;
    cell_id_w    = (id_group ? GROUP_SIZE : '0) + CellW'(ctrl.group);
  end

  // Next state of the tracking registers and the result valid flag.
  always_comb begin
    running_nxt   = running_r;
    best_nxt      = best_r;
    best_id_nxt   = best_id_r;
    best_ph_nxt   = best_ph_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (take_w) begin
      best_nxt    = best_eff_w;
      running_nxt = acc_w;
      if (ctrl.last) begin
        running_nxt   = '0;
        out_valid_nxt = 1'b1;
        if (better_w) begin
          best_nxt    = metric_ext_w;
          best_id_nxt = cell_id_w;
          best_ph_nxt = ctrl.phase;
        end
      end
    end
  end

  // Control and tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= '0;
      best_r      <= START_SCORE;
      best_id_r   <= '0;
      best_ph_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      running_r   <= running_nxt;
      best_r      <= best_nxt;
      best_id_r   <= best_id_nxt;
      best_ph_r   <= best_ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded when a hypothesis finishes.
  always_ff @(posedge clk) begin
    if (take_w && ctrl.last) begin
      metric_r   <= acc_w;
      score_r    <= best_nxt;
      cell_r     <= best_id_nxt;
      rotation_r <= best_ph_nxt;
      improved_r <= better_w;
    end
  end

  assign out_valid = out_valid_r;
  assign metric    = metric_r;
  assign score     = score_r;
  assign cell_id   = cell_r;
  assign rotation  = rotation_r;
  assign improved  = improved_r;

  `SHC_ASSERT_IMP(a_improved_copies_metric, clk, rst_n, out_valid_r && improved_r, $signed(score_r) == $signed({{(ScoreW-MetricW){metric_r[MetricW-1]}}, metric_r}))
  `SHC_ASSERT_IMP(a_best_not_below_metric, clk, rst_n, out_valid_r, $signed(score_r) >= $signed({{(ScoreW-MetricW){metric_r[MetricW-1]}}, metric_r}))
  `SHC_ASSERT_NEXT(a_start_resets_best, clk, rst_n, take_w && ctrl.start && !ctrl.last, best_r == START_SCORE && running_r == $past(acc_w))
  `SHC_ASSERT_NEXT(a_finish_gives_result, clk, rst_n, take_w && ctrl.last, out_valid_r && running_r == '0)

endmodule

>>> sv/sss_hypothesis_correlator.sv
// Top level of the SSS hypothesis correlator: two correlation lanes and the merge stage.
//
// Channel  Direction  Contents
// in_      slave      one element: two samples, two reference values, phase, group
// out_     master     one result per finished hypothesis: metric and best so far
// cfg_     write      identity group register
//
// One element is taken per cycle unless the pipeline stalls; it passes both lane stages
// before its result is registered. Each lane is a two-stage pipeline (rotation products,
// then reference product); the merge stage adds both lane terms into the running metric.
// Reset is synchronous and active low; it clears the metric, the best score to its
// start value, the pipeline valid flags and the result valid flag.
// The pipeline stalls only while an element that finishes a hypothesis reaches the
// merge stage and the previous result has not yet been taken.
module sss_hypothesis_correlator import shc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // first_re, first_im, second_re, second_im, ref_first, ref_second,
  // phase_index, group_number, zero fill
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,   // new_search
  input  logic                in_tlast,   // hyp_last
  input  logic                in_tvalid,
  output logic                in_tready,
  // hyp_metric, best_score, best_cell, best_rotation
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tuser,  // improved
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  shc_ctrl_t                 s1_ctrl_r, s2_ctrl_r, in_ctrl_w;
  logic                      id_group_r;
  logic                      adv_w, hold_w;
  logic [PhaseW-1:0]         phase_w;
  logic signed [SampleW-1:0] term0_w, term1_w;
  logic [MetricW-1:0]        metric_w;
  logic [ScoreW-1:0]         score_w;
  logic [CellW-1:0]          cell_w;
  logic [PhaseW-1:0]         rotation_w;

  assign adv_w     = !hold_w;
  assign in_tready = adv_w;

  // Phase index seven uses the last table row.
  assign phase_w = (in_tdata[98:96] > ROW_LAST) ? ROW_LAST : in_tdata[98:96];

  always_comb begin
    in_ctrl_w.valid = in_tvalid && in_tready;
    in_ctrl_w.start = in_tuser;
    in_ctrl_w.last  = in_tlast;
    in_ctrl_w.phase = phase_w;
    in_ctrl_w.group = in_tdata[106:99];
  end

  // Identity group register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_group_r <= 1'b0;
    end else if (cfg_wr_en) begin
      id_group_r <= cfg_wr_data;
    end
  end

  // Control fields follow the lane pipeline stage by stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
      s2_ctrl_r <= '0;
    end else if (adv_w) begin
      s1_ctrl_r <= in_ctrl_w;
      s2_ctrl_r <= s1_ctrl_r;
    end
  end

  // Lane for the first SSS symbol.
  shc_lane u_lane0 (
    .clk     (clk),
    .en      (adv_w),
    .samp_re ($signed(in_tdata[15:0])),
    .samp_im ($signed(in_tdata[31:16])),
    .ref_val ($signed(in_tdata[79:64])),
    .phase   (phase_w),
    .term    (term0_w)
  );

  // Lane for the second SSS symbol.
  shc_lane u_lane1 (
    .clk     (clk),
    .en      (adv_w),
    .samp_re ($signed(in_tdata[47:32])),
    .samp_im ($signed(in_tdata[63:48])),
    .ref_val ($signed(in_tdata[95:80])),
    .phase   (phase_w),
    .term    (term1_w)
  );

  shc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv_w),
    .ctrl      (s2_ctrl_r),
    .term0     (term0_w),
    .term1     (term1_w),
    .id_group  (id_group_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .metric    (metric_w),
    .score     (score_w),
    .cell_id   (cell_w),
    .rotation  (rotation_w),
    .improved  (out_tuser),
    .hold      (hold_w)
  );

  assign out_tdata = {rotation_w, cell_w, score_w, metric_w};

endmodule

>>> bench/tb_sss_hypothesis_correlator.sv
// Self-checking testbench for the SSS hypothesis correlator: directed table, then random searches.
module tb_sss_hypothesis_correlator;
  import shc_pkg::*;

  // One element as it is offered on the input stream.
  typedef struct packed {
    logic signed [15:0] fr;
    logic signed [15:0] fi;
    logic signed [15:0] sr;
    logic signed [15:0] si;
    logic signed [15:0] rf;
    logic signed [15:0] rs;
    logic [2:0]         ph;
    logic [7:0]         grp;
    logic               start;
    logic               last;
  } elem_t;

  // One finished hypothesis as it leaves the output stream.
  typedef struct packed {
    logic [23:0] metric;
    logic [27:0] score;
    logic [8:0]  cell_id;
    logic [2:0]  rot;
    logic        imp;
  } hyp_result_t;

  // A directed row; lit marks rows whose result is typed in.
  typedef struct packed {
    elem_t       e;
    logic        lit;
    hyp_result_t x;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // The first result after reset always beats the start score.
    '{'{0, 0, 0, 0, 0, 0, 3, 5, 1, 1}, 1, '{0, 0, 5, 3, 1}},
    // An equal metric leaves the best untouched.
    '{'{0, 0, 0, 0, 0, 0, 0, 7, 0, 1}, 1, '{0, 0, 5, 3, 0}},
    // Phase seven saturates to six; a group above 167 still forms a cell id.
    '{'{0, 0, 0, 0, 0, 0, 7, 200, 1, 1}, 1, '{0, 0, 200, 6, 1}},
    // Floor rounding of the rotation gives a metric of minus one.
    '{'{-1, 123, 0, 0, 1, 0, 3, 9, 1, 1}, 1, '{-1, -1, 9, 3, 1}},
    // A partial hypothesis is thrown away by the next search start.
    '{'{1000, -2000, 3000, -4000, 5000, -6000, 2, 20, 0, 0}, 0, '0},
    '{'{0, 0, 0, 0, 0, 0, 4, 21, 1, 1}, 1, '{0, 0, 21, 4, 1}},
    // Field extremes.
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, 3, 12, 1, 0}, 0, '0},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, 3, 12, 0, 1}, 0, '0},
    '{'{32767, 32767, 32767, 32767, 32767, 32767, 0, 13, 0, 1}, 0, '0},
    '{'{-32768, 32767, 32767, -32768, 32767, -32768, 6, 167, 0, 1}, 0, '0},
    '{'{32767, -32768, -32768, 32767, -32768, 32767, 1, 255, 0, 1}, 0, '0},
    // Every row of the phase table.
    '{'{1234, -5678, 910, -1112, 1314, -1516, 0, 30, 1, 0}, 0, '0},
    '{'{-2222, 3333, -4444, 5555, -6666, 7777, 1, 31, 0, 1}, 0, '0},
    '{'{17, -29, 31, -37, 41, -43, 2, 32, 0, 1}, 0, '0},
    '{'{-300, 400, -500, 600, -700, 800, 3, 33, 0, 0}, 0, '0},
    '{'{9999, -9999, 8888, -8888, 7777, -7777, 4, 34, 0, 1}, 0, '0},
    '{'{-12345, 23456, -3456, 456, -56, 6, 5, 35, 0, 1}, 0, '0},
    '{'{20000, 20000, -20000, -20000, 3, -3, 6, 36, 0, 1}, 0, '0},
    '{'{1, 1, 1, 1, -1, -1, 7, 37, 0, 1}, 0, '0},
    '{'{-1, -1, -1, -1, 32767, -32768, 2, 168, 1, 1}, 0, '0},
    '{'{0, 0, 0, 0, 0, 0, 5, 99, 0, 1}, 0, '0}
  };

  localparam int COS_Q15 [7] = '{16383, 25101, 30791, 32767, 30791, 25101, 16383};
  localparam int SIN_Q15 [7] = '{-28378, -21063, -11208, 0, 11207, 21062, 28377};

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  // first_re, first_im, second_re, second_im, ref_first, ref_second,
  // phase_index, group_number, zero fill
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;  // new_search
  logic                in_tlast = 1'b0;  // hyp_last
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // hyp_metric, best_score, best_cell, best_rotation
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;        // improved
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;

  // Shadow state of the correlator.
  logic signed [23:0] corr_sum = '0;
  logic signed [27:0] best_metric = START_SCORE;
  logic [8:0]         best_cell_id = '0;
  logic [2:0]         best_rot = '0;
  logic               id_grp_shadow = 1'b0;

  hyp_result_t pending_results[$];
  int          err_cnt = 0;
  int          tx_idle_pct = 18;
  int          rx_idle_pct = 18;
  int          rx_hold_req = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;

  sss_hypothesis_correlator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Rotated real part times the reference value, cut to 16 signed bits.
  function automatic logic signed [15:0] lane_term(input logic signed [15:0] re,
                                                   input logic signed [15:0] im,
                                                   input logic signed [15:0] refv,
                                                   input logic [2:0] row);
    longint c;
    longint s;
    longint rot;
    longint prod;
    c = COS_Q15[row];
    s = SIN_Q15[row];
    rot = ((c * re) >>> 15) - ((s * im) >>> 15);
    prod = rot * refv;
    return prod[15:0];
  endfunction

  // Folds one element into the metric; returns 1 when a hypothesis finishes.
  function automatic bit fold_element(input elem_t e, output hyp_result_t r);
    logic [2:0]         row;
    logic signed [23:0] t0;
    logic signed [23:0] t1;
    logic               better;
    row = (e.ph > ROW_LAST) ? ROW_LAST : e.ph;
    if (e.start) begin
      best_metric = START_SCORE;
      corr_sum = '0;
    end
    t0 = lane_term(e.fr, e.fi, e.rf, row);
    t1 = lane_term(e.sr, e.si, e.rs, row);
    corr_sum = corr_sum + t0 + t1;
    r = '0;
    if (!e.last) return 0;
    better = corr_sum > best_metric;
    if (better) begin
      best_metric = corr_sum;
      best_cell_id = (id_grp_shadow ? GROUP_SIZE : 9'd0) + {1'b0, e.grp};
      best_rot = row;
    end
    r = '{corr_sum, best_metric, best_cell_id, best_rot, better};
    corr_sum = '0;
    return 1;
  endfunction

  // Offers one element, waits for it to be taken and records its result.
  task automatic push_elem(input elem_t e, input bit use_lit, input hyp_result_t lit);
    hyp_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, e.grp, e.ph, e.rs, e.rf, e.si, e.sr, e.fi, e.fr};
    in_tuser <= e.start;
    in_tlast <= e.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (fold_element(e, r)) pending_results.push_back(use_lit ? lit : r);
  endtask

  // Sample values biased toward the extremes.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic elem_t rand_elem(input logic [2:0] ph, input logic [7:0] grp,
                                      input logic start, input logic last);
    elem_t e;
    e.fr = pick_sample();
    e.fi = pick_sample();
    e.sr = pick_sample();
    e.si = pick_sample();
    e.rf = pick_sample();
    e.rs = pick_sample();
    e.ph = ph;
    e.grp = grp;
    e.start = start;
    e.last = last;
    return e;
  endfunction

  function automatic logic [7:0] pick_group();
    return ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(167));
  endfunction

  // Mostly whole searches; some stray elements and runs that never finish.
  task automatic run_searches(input int budget);
    int          sent;
    int          kind;
    int          nhyp;
    int          len;
    bit          did_wrap;
    logic [2:0]  ph;
    logic [7:0]  grp;
    elem_t       e;
    sent = 0;
    did_wrap = 0;
    while (sent < budget) begin
      kind = $urandom_range(99);
      if (!did_wrap && sent > budget / 2) begin
        // A long hypothesis of largest negative terms wraps the 24-bit metric.
        did_wrap = 1;
        len = $urandom_range(130, 200);
        grp = pick_group();
        for (int k = 0; k < len; k++) begin
          e = '{-32768, -32768, -32768, -32768, -32768, -32768, 3'd3, grp, 1'b0, 1'b0};
          e.start = (k == 0);
          e.last = (k == len - 1);
          push_elem(e, 0, '0);
        end
        sent += len;
      end else if (kind < 80) begin
        nhyp = $urandom_range(1, 6);
        for (int h = 0; h < nhyp; h++) begin
          ph = 3'($urandom_range(7));
          grp = pick_group();
          len = $urandom_range(1, 10);
          for (int k = 0; k < len; k++)
            push_elem(rand_elem(ph, grp, h == 0 && k == 0, k == len - 1), 0, '0);
          sent += len;
        end
      end else if (kind < 90) begin
        push_elem(rand_elem(3'($urandom_range(7)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), 1'($urandom_range(1))), 0, '0);
        sent++;
      end else begin
        // A run that breaks off without its last element.
        ph = 3'($urandom_range(7));
        grp = pick_group();
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          push_elem(rand_elem(ph, grp, k == 0 && $urandom_range(1) == 1, 1'b0), 0, '0);
        sent += len;
      end
    end
  endtask

  // Lets every outstanding result arrive, then the pipeline empty out.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_id_group(input logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    id_grp_shadow = v;
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req != rx_hold_seen) begin
      out_tready <= 1'b0;
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    hyp_result_t want;
    hyp_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[23:0], out_tdata[51:24], out_tdata[60:52], out_tdata[63:61],
             out_tuser};
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: metric %0d score %0d cell %0d rot %0d imp %0b",
                   $signed(got.metric), $signed(got.score), got.cell_id, got.rot, got.imp);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch: expected metric %0d score %0d cell %0d rot %0d imp %0b,",
                      " got metric %0d score %0d cell %0d rot %0d imp %0b"},
                     $signed(want.metric), $signed(want.score), want.cell_id, want.rot,
                     want.imp, $signed(got.metric), $signed(got.score), got.cell_id,
                     got.rot, got.imp);
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      push_elem(DIRECTED[i].e, DIRECTED[i].lit, DIRECTED[i].x);
    settle();

    // Upper identity group, with one long receiver hold-off at the start.
    set_id_group(1'b1);
    rx_hold_req <= rx_hold_req + 1;
    run_searches(375);
    settle();

    // Lower identity group, no idling on either side.
    set_id_group(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_searches(375);
    settle();

    set_id_group(1'b1);
    tx_idle_pct = 18;
    rx_idle_pct <= 18;
    run_searches(375);
    settle();

    if (err_cnt == 0 && pending_results.size() == 0)
      $display("tb_sss_hypothesis_correlator: done, clean");
    else
      $display("tb_sss_hypothesis_correlator: done, errors");
    $finish;
  end

  // Watchdog.
  initial begin
    #1600000;
    $display("tb_sss_hypothesis_correlator: done, errors");
    $finish;
  end

endmodule
